[src/cfmm_pkg.sv]
// complex field mask modulator: shared constants, command codes, cordic control type
// and the cordic arctangent table; no dependencies
`timescale 1ns / 1ps

package cfmm_pkg;

  // default sizes
  localparam int CORDIC_STEPS_DEF = 16;
  localparam int FIELD_BITS_DEF   = 18;
  localparam int MASK_BITS_DEF    = 24;

  // fixed point formats
  localparam int FIELD_FRAC = 14;
  localparam int GUARD      = 16;

  // cordic gain compensation, q32
  localparam logic [31:0] INV_GAIN = 32'h9B74EDA8;

  // radians (q8) to turns (q56): 2^48 / (2 pi), split into two partial products
  localparam logic [31:0] TURN_LO = 32'h00DB9391;
  localparam logic [31:0] TURN_HI = 32'h0028BE60;
  localparam int          TURN_LO_BITS = 24;

  // command codes
  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_SCAN  = 2'd1;
  localparam logic [1:0] CMD_APPLY = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_MASK_KIND  = 2'd0;
  localparam logic [1:0] CFG_SUBSTITUTE = 2'd1;
  localparam logic [1:0] CFG_NORMALIZE  = 2'd2;

  typedef struct packed {
    logic start;
    logic vec;     // 1 vectoring, 0 rotation
  } cordic_ctl_t;

  // arctangent of 2^-i in q32 turns
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    unique case (i)
      5'd0:    v = 32'h20000000;
      5'd1:    v = 32'h12E4051E;
      5'd2:    v = 32'h09FB385B;
      5'd3:    v = 32'h051111D4;
      5'd4:    v = 32'h028B0D43;
      5'd5:    v = 32'h0145D7E1;
      5'd6:    v = 32'h00A2F61E;
      5'd7:    v = 32'h00517C55;
      5'd8:    v = 32'h0028BE53;
      5'd9:    v = 32'h00145F2F;
      5'd10:   v = 32'h000A2F98;
      5'd11:   v = 32'h000517CC;
      5'd12:   v = 32'h00028BE6;
      5'd13:   v = 32'h000145F3;
      5'd14:   v = 32'h0000A2FA;
      5'd15:   v = 32'h0000517D;
      5'd16:   v = 32'h000028BE;
      5'd17:   v = 32'h0000145F;
      5'd18:   v = 32'h00000A30;
      5'd19:   v = 32'h00000518;
      5'd20:   v = 32'h0000028C;
      5'd21:   v = 32'h00000146;
      5'd22:   v = 32'h000000A3;
      5'd23:   v = 32'h00000051;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

endpackage

[src/cfmm_root.sv]
// iterative divider and square root sharing one subtract/compare unit
// computes floor(sqrt(floor(num * 2^32 / den))); uses cfmm_pkg sizes
`timescale 1ns / 1ps

module cfmm_root #(
  parameter int MASK_BITS = cfmm_pkg::MASK_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic [MASK_BITS-2:0]                 num,
  input  logic [MASK_BITS+1:0]                 den,
  output logic [(MASK_BITS+32)/2-1:0]          root,
  output logic                                 done
);

  localparam int QW  = MASK_BITS + 31;
  localparam int SW  = (QW + 1) / 2;
  localparam int DW  = MASK_BITS + 2;
  localparam int UW  = (DW + 1 > SW + 3) ? DW + 1 : SW + 3;
  localparam int CTW = $clog2(QW);

  localparam logic [1:0] R_IDLE = 2'd0;
  localparam logic [1:0] R_DIV  = 2'd1;
  localparam logic [1:0] R_SQRT = 2'd2;

  logic [1:0]      phase;
  logic [CTW-1:0]  cnt;
  logic [QW-1:0]   nq;
  logic [DW-1:0]   rem;
  logic [DW-1:0]   dv;
  logic [2*SW-1:0] rad;
  logic [SW:0]     rem_s;
  logic [SW-1:0]   res;

  // shared subtractor
  logic [UW-1:0] sub_a, sub_b;
  logic [UW:0]   diff;
  logic          ge;

  always_comb begin
    if (phase == R_SQRT) begin
      sub_a = UW'({rem_s, rad[2*SW-1 -: 2]});
      sub_b = UW'({res, 2'b01});
    end else begin
      sub_a = UW'({rem, nq[QW-1]});
      sub_b = UW'(dv);
    end
    diff = {1'b0, sub_a} - {1'b0, sub_b};
    ge   = !diff[UW];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= R_IDLE;
      done  <= 1'b0;
    end else begin
      done <= (phase == R_SQRT) && (cnt == CTW'(SW - 1));
      unique case (phase)
        R_IDLE: begin
          if (start) begin
            phase <= R_DIV;
            cnt   <= '0;
            nq    <= {num, 32'd0};
            rem   <= '0;
            dv    <= den;
          end
        end
        R_DIV: begin
          rem <= ge ? diff[DW-1:0] : sub_a[DW-1:0];
          nq  <= {nq[QW-2:0], ge};
          if (cnt == CTW'(QW - 1)) begin
            phase <= R_SQRT;
            cnt   <= '0;
            rad   <= (2*SW)'({nq[QW-2:0], ge});
            rem_s <= '0;
            res   <= '0;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        R_SQRT: begin
          rem_s <= ge ? diff[SW:0] : sub_a[SW:0];
          res   <= {res[SW-2:0], ge};
          rad   <= rad << 2;
          if (cnt == CTW'(SW - 1)) begin
            phase <= R_IDLE;
          end else begin
            cnt <= cnt + 1'b1;
          end
        end
        default: phase <= R_IDLE;
      endcase
    end
  end

  assign root = res;

endmodule

[src/cfmm_cordic.sv]
// iterative cordic: one shift-add stage reused each cycle, vectoring or rotation
// uses cfmm_pkg (control type, arctangent table)
`timescale 1ns / 1ps

module cfmm_cordic #(
  parameter int XW    = 47,
  parameter int STEPS = cfmm_pkg::CORDIC_STEPS_DEF
) (
  input  logic                     clk,
  input  logic                     rst,
  input  cfmm_pkg::cordic_ctl_t    ctl,
  input  logic signed [XW-1:0]     x_in,
  input  logic signed [XW-1:0]     y_in,
  input  logic signed [31:0]       a_in,
  output logic signed [XW-1:0]     x_out,
  output logic signed [XW-1:0]     y_out,
  output logic [31:0]              z_out,
  output logic                     done
);

  localparam int IW = $clog2(STEPS);
  localparam int ZW = 34;
  localparam logic signed [ZW-1:0] QUARTER = ZW'(34'sh040000000);
  localparam logic signed [ZW-1:0] HALF    = ZW'(34'sh080000000);
  localparam logic signed [31:0]   QTR32   = 32'sh40000000;

  logic                  busy;
  logic                  vec;
  logic                  zero;
  logic [IW-1:0]         idx;
  logic signed [XW-1:0]  x, y;
  logic signed [ZW-1:0]  z;

  logic signed [XW-1:0]  dx, dy;
  logic signed [ZW-1:0]  at;
  logic                  up;

  always_comb begin
    dx = y >>> idx;
    dy = x >>> idx;
    at = ZW'(cfmm_pkg::atan_turn(5'(idx)));
    // same update for vectoring with y below zero and rotation with angle not below zero
    up = vec ? y[XW-1] : !z[ZW-1];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && !ctl.start && (idx == IW'(STEPS - 1));
      if (ctl.start) begin
        busy <= 1'b1;
        vec  <= ctl.vec;
        idx  <= '0;
        if (ctl.vec) begin
          zero <= (x_in == '0) && (y_in == '0);
          if (x_in[XW-1]) begin
            x <= -x_in;
            y <= -y_in;
            z <= HALF;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= '0;
          end
        end else begin
          zero <= 1'b0;
          if (a_in > QTR32) begin
            x <= -y_in;
            y <= x_in;
            z <= ZW'(a_in) - QUARTER;
          end else if (a_in < -QTR32) begin
            x <= y_in;
            y <= -x_in;
            z <= ZW'(a_in) + QUARTER;
          end else begin
            x <= x_in;
            y <= y_in;
            z <= ZW'(a_in);
          end
        end
      end else if (busy) begin
        if (up) begin
          x <= x - dx;
          y <= y + dy;
          z <= z - at;
        end else begin
          x <= x + dx;
          y <= y - dy;
          z <= z + at;
        end
        if (idx == IW'(STEPS - 1)) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + 1'b1;
        end
      end
    end
  end

  assign x_out = x;
  assign y_out = y;
  assign z_out = zero ? 32'd0 : z[31:0];

endmodule

[src/complex_field_mask_modulator_unit.sv]
// complex field mask modulator, top level: config registers, running maximum,
// sequencer around one shared 32x32 multiplier; uses cfmm_pkg, cfmm_root, cfmm_cordic
`timescale 1ns / 1ps

//  channel | signals                                         | handshake
//  --------+-------------------------------------------------+----------------------------
//  in      | command, mask_value, field_real, field_imag     | in_valid / in_stall
//  out     | out_real, out_imag, negative_mask               | out_valid / out_stall
//  cfg     | cfg_index, cfg_data                             | cfg_valid / cfg_ready
//
//  clear, scan and unused commands finish in the accepting cycle
//  an apply beat holds the block for its whole computation: the divider, the square root,
//  each cordic pass, ST_MQ_LO, ST_MQ_HI and ST_MQ_END per gain product, ST_IMUL_A to ST_IMUL_C
//  for both intensity products,
//  plus the sequencing states
//  synchronous active-high reset clears control, config and the running maximum
//  a finished result waits in the output register while the next beat is taken

module complex_field_mask_modulator_unit #(
  parameter int CORDIC_STEPS = cfmm_pkg::CORDIC_STEPS_DEF,
  parameter int FIELD_BITS   = cfmm_pkg::FIELD_BITS_DEF,
  parameter int MASK_BITS    = cfmm_pkg::MASK_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // input beats
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [1:0]                   command,
  input  logic signed [MASK_BITS-1:0]  mask_value,
  input  logic signed [FIELD_BITS-1:0] field_real,
  input  logic signed [FIELD_BITS-1:0] field_imag,
  // result beats
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [FIELD_BITS-1:0] out_real,
  output logic signed [FIELD_BITS-1:0] out_imag,
  output logic                         negative_mask,
  // config writes
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [1:0]                   cfg_index,
  input  logic                         cfg_data
);

  localparam int QW  = MASK_BITS + 31;
  localparam int SW  = (QW + 1) / 2;
  localparam int DW  = MASK_BITS + 2;
  localparam int XA  = SW + 17;
  localparam int XB  = FIELD_BITS + 19;
  localparam int XC  = FIELD_BITS + SW + 1;
  localparam int XAB = (XA > XB) ? XA : XB;
  // width of the working x/y registers
  localparam int XW  = (XAB > XC) ? XAB : XC;
  localparam int RW  = XW + 1 - cfmm_pkg::GUARD;

  localparam logic signed [XW:0]   ROUND_HALF = (XW+1)'(1 << (cfmm_pkg::GUARD - 1));
  localparam logic signed [RW-1:0] SAT_HI = RW'((64'sd1 <<< (FIELD_BITS - 1)) - 64'sd1);
  localparam logic signed [RW-1:0] SAT_LO = RW'(-(64'sd1 <<< (FIELD_BITS - 1)));
  localparam logic [DW-1:0]        UNIT_MAX = DW'(256);

  // sequencer states
  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_ROOT     = 4'd1;
  localparam logic [3:0] ST_IMUL_A   = 4'd2;
  localparam logic [3:0] ST_IMUL_B   = 4'd3;
  localparam logic [3:0] ST_IMUL_C   = 4'd4;
  localparam logic [3:0] ST_TURN_A   = 4'd5;
  localparam logic [3:0] ST_TURN_B   = 4'd6;
  localparam logic [3:0] ST_TURN_C   = 4'd7;
  localparam logic [3:0] ST_VEC_GO   = 4'd8;
  localparam logic [3:0] ST_VEC_WAIT = 4'd9;
  localparam logic [3:0] ST_MQ_LO    = 4'd10;
  localparam logic [3:0] ST_MQ_HI    = 4'd11;
  localparam logic [3:0] ST_MQ_END   = 4'd12;
  localparam logic [3:0] ST_ROT_GO   = 4'd13;
  localparam logic [3:0] ST_ROT_WAIT = 4'd14;
  localparam logic [3:0] ST_OUT      = 4'd15;

  logic [3:0] state;

  // config and running maximum
  logic mask_kind, substitute, normalize;
  logic signed [MASK_BITS-1:0] running_max;

  // latched beat
  logic signed [MASK_BITS-1:0]  mv;
  logic signed [FIELD_BITS-1:0] pix_re, pix_im;

  // working values
  logic signed [XW-1:0] x, y;
  logic signed [31:0]   ang;
  logic                 flag;
  logic [55:0]          hold;
  logic [1:0]           mq_cnt;
  logic                 mq_tgt;   // 0 scales x, 1 scales y

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;

  logic                       in_fire;
  logic                       out_load;
  logic                       flag_case;
  logic                       root_start, root_done;
  logic [SW-1:0]              root_s;
  logic [DW-1:0]              root_den;
  cfmm_pkg::cordic_ctl_t      cctl;
  logic signed [XW-1:0]       cx, cy;
  logic [31:0]                cz;
  logic                       cdone;

  logic [FIELD_BITS-1:0] re_mag, im_mag;
  logic [MASK_BITS-1:0]  mv_mag;
  logic signed [XW-1:0]  mq_v;
  logic [XW-1:0]         mq_mag;
  logic [XW-1:0]         mq_res_mag;
  logic signed [XW-1:0]  mq_res;
  logic [55:0]           turn_sum;
  logic [55:0]           turn;
  logic [XW-1:0]         prod_ext;

  // round half up out of the guard bits, then saturate
  function automatic logic signed [FIELD_BITS-1:0] pack_q(input logic signed [XW-1:0] v);
    logic signed [XW:0]   sum;
    logic signed [RW-1:0] r;
    sum = (XW+1)'(v) + ROUND_HALF;
    r   = sum[XW:cfmm_pkg::GUARD];
    if (r > SAT_HI) begin
      r = SAT_HI;
    end else if (r < SAT_LO) begin
      r = SAT_LO;
    end
    return r[FIELD_BITS-1:0];
  endfunction

  assign in_stall  = (state != ST_IDLE);
  assign in_fire   = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_load  = (state == ST_OUT) && (!out_valid || !out_stall);

  // negative intensity or an empty normalizing maximum
  assign flag_case  = !mask_kind && (mask_value[MASK_BITS-1] ||
                      (normalize && (running_max == '0)));
  assign root_start = in_fire && (command == cfmm_pkg::CMD_APPLY) && !flag_case
                      && !mask_kind;
  assign root_den   = normalize ? DW'($unsigned(running_max)) : UNIT_MAX;

  always_comb begin
    re_mag     = pix_re[FIELD_BITS-1] ? (~pix_re + 1'b1) : pix_re;
    im_mag     = pix_im[FIELD_BITS-1] ? (~pix_im + 1'b1) : pix_im;
    mv_mag     = mv[MASK_BITS-1] ? (~mv + 1'b1) : mv;
    mq_v       = mq_tgt ? y : x;
    mq_mag     = mq_v[XW-1] ? XW'(-mq_v) : XW'(mq_v);
    mq_res_mag = XW'(mul_p) + XW'(hold[31:0]);
    mq_res     = mq_v[XW-1] ? -$signed(mq_res_mag) : $signed(mq_res_mag);
    turn_sum   = hold + {mul_p[31:0], 24'd0};
    turn       = mv[MASK_BITS-1] ? (~turn_sum + 1'b1) : turn_sum;
    prod_ext   = XW'(mul_p);
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_IMUL_A: begin
        mul_a = 32'(re_mag);
        mul_b = 32'(root_s);
      end
      ST_IMUL_B: begin
        mul_a = 32'(im_mag);
        mul_b = 32'(root_s);
      end
      ST_TURN_A: begin
        mul_a = 32'(mv_mag);
        mul_b = cfmm_pkg::TURN_LO;
      end
      ST_TURN_B: begin
        mul_a = 32'(mv_mag);
        mul_b = cfmm_pkg::TURN_HI;
      end
      ST_MQ_LO: begin
        mul_a = mq_mag[31:0];
        mul_b = cfmm_pkg::INV_GAIN;
      end
      ST_MQ_HI: begin
        mul_a = 32'(mq_mag >> 32);
        mul_b = cfmm_pkg::INV_GAIN;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p <= mul_a * mul_b;
  end

  always_comb begin
    cctl.start = (state == ST_VEC_GO) || (state == ST_ROT_GO);
    cctl.vec   = (state == ST_VEC_GO);
  end

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mask_kind  <= 1'b0;
      substitute <= 1'b0;
      normalize  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        cfmm_pkg::CFG_MASK_KIND:  mask_kind  <= cfg_data;
        cfmm_pkg::CFG_SUBSTITUTE: substitute <= cfg_data;
        cfmm_pkg::CFG_NORMALIZE:  normalize  <= cfg_data;
        default: ;
      endcase
    end
  end

  // result valid: set when the result register loads, cleared when the beat leaves
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // sequencer and datapath
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      running_max <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_fire) begin
            mv     <= mask_value;
            pix_re <= field_real;
            pix_im <= field_imag;
            unique case (command)
              cfmm_pkg::CMD_CLEAR: running_max <= '0;
              cfmm_pkg::CMD_SCAN: begin
                if (mask_value > running_max) begin
                  running_max <= mask_value;
                end
              end
              cfmm_pkg::CMD_APPLY: begin
                // flagged pixels leave as zero
                flag <= flag_case;
                x    <= flag_case ? '0 : (XW'(field_real) <<< cfmm_pkg::GUARD);
                y    <= flag_case ? '0 : (XW'(field_imag) <<< cfmm_pkg::GUARD);
                if (mask_kind) begin
                  state <= ST_TURN_A;
                end else if (flag_case) begin
                  state <= ST_OUT;
                end else begin
                  state <= ST_ROOT;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ROOT: begin
          if (root_done) begin
            state <= substitute ? ST_VEC_GO : ST_IMUL_A;
          end
        end
        ST_IMUL_A: state <= ST_IMUL_B;
        ST_IMUL_B: begin
          x     <= pix_re[FIELD_BITS-1] ? -$signed(prod_ext) : $signed(prod_ext);
          state <= ST_IMUL_C;
        end
        ST_IMUL_C: begin
          y     <= pix_im[FIELD_BITS-1] ? -$signed(prod_ext) : $signed(prod_ext);
          state <= ST_OUT;
        end
        ST_TURN_A: state <= ST_TURN_B;
        ST_TURN_B: begin
          hold  <= mul_p[55:0];
          state <= ST_TURN_C;
        end
        ST_TURN_C: begin
          ang    <= $signed(turn[55:24]);
          mq_cnt <= 2'd2;
          mq_tgt <= 1'b0;
          state  <= substitute ? ST_VEC_GO : ST_MQ_LO;
        end
        ST_VEC_GO: state <= ST_VEC_WAIT;
        ST_VEC_WAIT: begin
          if (cdone) begin
            mq_tgt <= 1'b0;
            y      <= '0;
            if (mask_kind) begin
              // phase substitute: magnitude takes the gain correction twice
              x      <= cx;
              mq_cnt <= 2'd2;
            end else begin
              ang    <= $signed(cz);
              x      <= XW'(root_s) <<< cfmm_pkg::FIELD_FRAC;
              mq_cnt <= 2'd1;
            end
            state <= ST_MQ_LO;
          end
        end
        ST_MQ_LO: state <= ST_MQ_HI;
        ST_MQ_HI: begin
          hold  <= 56'(mul_p[63:32]);
          state <= ST_MQ_END;
        end
        ST_MQ_END: begin
          if (mq_tgt) begin
            y <= mq_res;
          end else begin
            x <= mq_res;
          end
          mq_cnt <= mq_cnt - 1'b1;
          if (mq_cnt == 2'd1) begin
            state <= ST_ROT_GO;
          end else begin
            // phase multiply scales y next, phase substitute scales x again
            mq_tgt <= !substitute;
            state  <= ST_MQ_LO;
          end
        end
        ST_ROT_GO: state <= ST_ROT_WAIT;
        ST_ROT_WAIT: begin
          if (cdone) begin
            x     <= cx;
            y     <= cy;
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_real      <= pack_q(x);
      out_imag      <= pack_q(y);
      negative_mask <= flag;
    end
  end

  cfmm_root #(
    .MASK_BITS (MASK_BITS)
  ) u_root (
    .clk   (clk),
    .rst   (rst),
    .start (root_start),
    .num   (mask_value[MASK_BITS-2:0]),
    .den   (root_den),
    .root  (root_s),
    .done  (root_done)
  );

  cfmm_cordic #(
    .XW    (XW),
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .ctl   (cctl),
    .x_in  (x),
    .y_in  (y),
    .a_in  (ang),
    .x_out (cx),
    .y_out (cy),
    .z_out (cz),
    .done  (cdone)
  );

  // a clear beat leaves the maximum at zero
  a_clear_max: assert property (@(posedge clk) disable iff (rst)
    (in_fire && command == cfmm_pkg::CMD_CLEAR) |=> running_max == '0)
    else $error("running maximum not cleared");

  // the root unit only finishes while the sequencer waits for it
  a_root_done: assert property (@(posedge clk) disable iff (rst)
    root_done |-> state == ST_ROOT)
    else $error("root result outside its wait state");

  // cordic only finishes while the sequencer waits for it
  a_cordic_done: assert property (@(posedge clk) disable iff (rst)
    cdone |-> (state == ST_VEC_WAIT || state == ST_ROT_WAIT))
    else $error("cordic result outside its wait state");

  // a flagged result is the zero pixel
  a_flag_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && negative_mask) |-> (out_real == '0 && out_imag == '0))
    else $error("flagged result not zero");

  // phase masks never raise the flag
  a_phase_noflag: assert property (@(posedge clk) disable iff (rst)
    (out_load && mask_kind) |=> !negative_mask)
    else $error("flag raised in phase mode");

endmodule
